// ===== rtl/spct_pkg.sv =====
`default_nettype none
package spct_pkg;

  // table geometry
  localparam int SETS    = 256;
  localparam int WAYS    = 4;
  localparam int SET_W   = $clog2(SETS);
  localparam int ROW_W   = SET_W + 1;
  localparam int ROWS    = 2 * SETS;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MSG_W   = 96;

  localparam logic [31:0] CRC_POLY     = 32'h82F63B78;
  localparam logic [31:0] INTERVAL_RST = 32'd30000;

  // entry flag bits
  localparam logic [5:0] FLG_RESET  = 6'd1;
  localparam logic [5:0] FLG_CLOSED = 6'd2;
  localparam logic [5:0] FLG_LVER   = 6'd4;
  localparam logic [5:0] FLG_RVER   = 6'd8;
  localparam logic [5:0] FLG_LFIN   = 6'd16;
  localparam logic [5:0] FLG_RFIN   = 6'd32;
  localparam logic [5:0] FLG_VER    = 6'd12;
  localparam logic [5:0] FLG_FINS   = 6'd48;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_FINAL,
    OP_UPDATE,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE,
    ST_NOTFOUND,
    ST_FLAGS,
    ST_AWAIT,
    ST_RESET,
    ST_CLOSED,
    ST_FULL
  } status_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_RDCUR,
    B_EXEC,
    B_WBOLD,
    B_CLEAR
  } bst_t;

  typedef struct packed {
    op_t              kind;
    logic [31:0]      src_ip;
    logic [31:0]      dst_ip;
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
    logic [31:0]      seq;
    logic             rst;
    logic             lfin;
    logic             rfin;
    logic             ack;
    logic [SET_W-1:0] set;
  } item_t;

  typedef struct packed {
    logic        vld;
    item_t       item;
  } iq_t;

  typedef struct packed {
    logic        vld;
    logic [63:0] ka;
    logic [31:0] kp;
    logic [31:0] off;
    logic [5:0]  flg;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic [5:0]  state;
    logic        swapped;
  } result_t;

  // mask of message bits feeding crc bit ob (crc is linear, init zero)
  function automatic logic [MSG_W-1:0] crc_mask(input int ob);
    logic [MSG_W-1:0] m;
    logic [31:0]      c;
    logic             fb;
    m = '0;
    for (int i = 0; i < MSG_W; i++) begin
      c = '0;
      for (int n = 0; n < MSG_W; n++) begin
        fb = c[0] ^ (n == i);
        c  = (c >> 1) ^ (fb ? CRC_POLY : 32'd0);
      end
      m[i] = c[ob];
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/spct_front.sv =====
`default_nettype none
module spct_front
  import spct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_src_ip,
  input  wire logic [31:0] in_dst_ip,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic [31:0] in_seq_number,
  input  wire logic        in_saw_reset,
  input  wire logic        in_saw_left_fin,
  input  wire logic        in_saw_right_fin,
  input  wire logic        in_is_ack,
  output iq_t              iq,
  input  wire logic        iq_pop
);

  logic [MSG_W-1:0] msg;
  logic [SET_W-1:0] set;
  item_t            new_item;
  item_t            ent_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  logic             push_ok;
  logic             pop_ok;

  // hash message, bytes least significant first
  assign msg = {in_src_port, in_dst_port, in_dst_ip, in_src_ip};

  // set index: low crc bits as parity of fixed masks
  for (genvar g = 0; g < SET_W; g++) begin : g_crc
    localparam logic [MSG_W-1:0] MASK = crc_mask(g);
    assign set[g] = ^(msg & MASK);
  end

  always_comb begin
    new_item.kind     = op_t'(in_kind);
    new_item.src_ip   = in_src_ip;
    new_item.dst_ip   = in_dst_ip;
    new_item.src_port = in_src_port;
    new_item.dst_port = in_dst_port;
    new_item.seq      = in_seq_number;
    new_item.rst      = in_saw_reset;
    new_item.lfin     = in_saw_left_fin;
    new_item.rfin     = in_saw_right_fin;
    new_item.ack      = in_is_ack;
    new_item.set      = set;
  end

  // two-entry item queue
  assign full    = (cnt_r == 2'd2);
  assign push_ok = push && !full;
  assign iq.vld  = (cnt_r != 2'd0);
  assign iq.item = ent_r[rp_r];
  assign pop_ok  = iq_pop && iq.vld;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) begin
        wp_r <= ~wp_r;
      end
      if (pop_ok) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ent_r[wp_r] <= new_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/spct_back.sv =====
`default_nettype none
module spct_back
  import spct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire iq_t         iq,
  output logic             iq_pop,
  output result_t          res,
  output logic             res_vld,
  input  wire logic        res_pop
);

  bst_t             state_r;
  bst_t             state_nxt;
  logic             bank_r;
  logic [31:0]      elapsed_r;
  logic [31:0]      ival_r;
  item_t            itm_r;
  row_t             cur_row_r;
  row_t             wb_row_r;
  logic [ROW_W-1:0] wb_addr_r;
  logic             sw_pend_r;
  logic [ROW_W-1:0] cnt_r;
  logic             out_vld_r;
  result_t          res_r;
  result_t          res_nxt;
  logic             res_push;

  // row memory: one row per bank and set
  row_t             mem [ROWS];
  row_t             rdata_r;
  logic [ROW_W-1:0] mem_raddr;
  logic             mem_we;
  logic [ROW_W-1:0] mem_waddr;
  row_t             mem_wdata;

  // execute stage signals
  row_t             old_row;
  row_t             wr_row;
  row_t             wb_row;
  logic [63:0]      ka;
  logic [31:0]      kp;
  logic             hc_any, ho_any, fr_any;
  logic [WAY_W-1:0] hc_i, ho_i, fr_i, loc_i;
  logic             moved, found, in_cur;
  way_t             e, en;
  logic [5:0]       f;
  status_t          ex_status;
  logic [31:0]      ex_off;
  logic [5:0]       ex_st;
  logic             ex_chk, ex_wr, ex_cur, ex_moved, ex_sw;
  logic [ROW_W-1:0] ex_addr;
  logic             start;

  assign start = (state_r == B_IDLE) && iq.vld && !out_vld_r;

  // operation on the two rows of the set
  always_comb begin
    old_row = rdata_r;
    ka      = {itm_r.src_ip, itm_r.dst_ip};
    kp      = {itm_r.src_port, itm_r.dst_port};
    hc_any  = 1'b0;
    ho_any  = 1'b0;
    fr_any  = 1'b0;
    hc_i    = '0;
    ho_i    = '0;
    fr_i    = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cur_row_r[w].vld && cur_row_r[w].ka == ka && cur_row_r[w].kp == kp) begin
        hc_any = 1'b1;
        hc_i   = WAY_W'(w);
      end
      if (old_row[w].vld && old_row[w].ka == ka && old_row[w].kp == kp) begin
        ho_any = 1'b1;
        ho_i   = WAY_W'(w);
      end
      if (!cur_row_r[w].vld) begin
        fr_any = 1'b1;
        fr_i   = WAY_W'(w);
      end
    end
    moved  = !hc_any && ho_any && fr_any;
    found  = hc_any || ho_any;
    in_cur = hc_any || moved;
    loc_i  = hc_any ? hc_i : (moved ? fr_i : ho_i);
    e      = hc_any ? cur_row_r[hc_i] : old_row[ho_i];
    en     = e;
    en.vld = 1'b1;
    f      = e.flg;

    ex_status = ST_DONE;
    ex_off    = '0;
    ex_st     = '0;
    ex_chk    = 1'b1;
    ex_wr     = 1'b0;
    ex_cur    = in_cur;
    ex_moved  = 1'b0;
    wr_row    = in_cur ? cur_row_r : old_row;

    unique case (itm_r.kind)
      OP_INSERT: begin
        ex_cur = 1'b1;
        wr_row = cur_row_r;
        if (hc_any || fr_any) begin
          ex_wr = 1'b1;
          wr_row[hc_any ? hc_i : fr_i] = '{vld: 1'b1, ka: ka, kp: kp,
                                           off: itm_r.seq, flg: FLG_LVER};
        end else begin
          ex_status = ST_FULL;
        end
      end
      OP_FINAL: begin
        if (!found) begin
          ex_status = ST_NOTFOUND;
        end else begin
          ex_wr    = 1'b1;
          ex_moved = moved;
          if ((e.flg & FLG_VER) != FLG_LVER) begin
            ex_status = ST_FLAGS;
          end else begin
            en.off = itm_r.seq - e.off + 32'd1;
            en.flg = e.flg | FLG_RVER;
          end
          ex_off        = en.off;
          ex_st         = en.flg;
          wr_row[loc_i] = en;
        end
      end
      OP_UPDATE: begin
        if (!found) begin
          ex_status = ST_NOTFOUND;
        end else begin
          ex_wr    = 1'b1;
          ex_moved = moved;
          if ((e.flg & FLG_VER) == FLG_LVER) begin
            ex_status = ST_AWAIT;
          end else if ((e.flg & FLG_VER) != FLG_VER) begin
            ex_status = ST_FLAGS;
          end else if ((e.flg & FLG_RESET) != 6'd0) begin
            ex_status = ST_RESET;
            ex_chk    = 1'b0;
          end else begin
            if (itm_r.rst) begin
              f = f | FLG_RESET;
            end
            if ((f & FLG_CLOSED) != 6'd0) begin
              ex_status = ST_CLOSED;
              ex_chk    = 1'b0;
            end else begin
              if ((f & FLG_FINS) == FLG_FINS && itm_r.ack) begin
                f = f | FLG_CLOSED;
              end
              if (itm_r.lfin) begin
                f = f | FLG_LFIN;
              end
              if (itm_r.rfin) begin
                f = f | FLG_RFIN;
              end
              ex_off = e.off;
              ex_st  = f;
            end
            en.flg = f;
          end
          wr_row[loc_i] = en;
        end
      end
      OP_TICK: begin
        ex_chk = 1'b0;
      end
      default: begin
        ex_chk = 1'b0;
      end
    endcase

    ex_addr           = {(ex_cur ? bank_r : ~bank_r), itm_r.set};
    ex_sw             = ex_chk && (elapsed_r > ival_r);
    wb_row            = old_row;
    wb_row[ho_i].vld  = 1'b0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_INIT: begin
        if (cnt_r == ROW_W'(ROWS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (start && iq.item.kind != OP_TICK) begin
          state_nxt = B_RDCUR;
        end
      end
      B_RDCUR: begin
        state_nxt = B_EXEC;
      end
      B_EXEC: begin
        if (ex_moved) begin
          state_nxt = B_WBOLD;
        end else if (ex_sw) begin
          state_nxt = B_CLEAR;
        end else begin
          state_nxt = B_IDLE;
        end
      end
      B_WBOLD: begin
        state_nxt = sw_pend_r ? B_CLEAR : B_IDLE;
      end
      B_CLEAR: begin
        if (cnt_r[SET_W-1:0] == {SET_W{1'b1}}) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_INIT;
      end
    endcase
  end

  // memory control and result transfer
  always_comb begin
    iq_pop    = start;
    mem_raddr = {bank_r, iq.item.set};
    mem_we    = 1'b0;
    mem_waddr = ex_addr;
    mem_wdata = wr_row;
    res_push  = 1'b0;
    res_nxt   = '{status: ST_DONE, offset: 32'd0, state: 6'd0, swapped: 1'b0};
    unique case (state_r)
      B_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = '0;
      end
      B_IDLE: begin
        res_push = start && (iq.item.kind == OP_TICK);
      end
      B_RDCUR: begin
        mem_raddr = {~bank_r, itm_r.set};
      end
      B_EXEC: begin
        mem_we   = ex_wr;
        res_push = 1'b1;
        res_nxt  = '{status: ex_status, offset: ex_off, state: ex_st, swapped: ex_sw};
      end
      B_WBOLD: begin
        mem_we    = 1'b1;
        mem_waddr = wb_addr_r;
        mem_wdata = wb_row_r;
      end
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {bank_r, cnt_r[SET_W-1:0]};
        mem_wdata = '0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_INIT;
      cnt_r     <= '0;
      bank_r    <= 1'b0;
      elapsed_r <= '0;
      ival_r    <= INTERVAL_RST;
      out_vld_r <= 1'b0;
      sw_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_INIT || state_r == B_CLEAR) begin
        cnt_r <= cnt_r + ROW_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (cfg_we) begin
        ival_r <= cfg_wdata;
      end
      if (state_r == B_EXEC && ex_sw) begin
        bank_r    <= ~bank_r;
        elapsed_r <= '0;
      end else if (start && iq.item.kind == OP_TICK && elapsed_r != 32'hFFFF_FFFF) begin
        elapsed_r <= elapsed_r + 32'd1;
      end
      if (state_r == B_EXEC) begin
        sw_pend_r <= ex_sw;
      end
      if (res_push) begin
        out_vld_r <= 1'b1;
      end else if (res_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (iq_pop) begin
      itm_r <= iq.item;
    end
    if (state_r == B_RDCUR) begin
      cur_row_r <= rdata_r;
    end
    if (state_r == B_EXEC) begin
      wb_row_r  <= wb_row;
      wb_addr_r <= {~bank_r, itm_r.set};
    end
    if (res_push) begin
      res_r <= res_nxt;
    end
  end

  // row memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign res     = res_r;
  assign res_vld = out_vld_r;

endmodule
`default_nettype wire

// ===== rtl/syn_proxy_connection_table_top.sv =====
`default_nettype none
// Two-bank TCP flow table for a SYN proxy. Items enter through a two-entry
// queue (push/full) and results leave through a one-entry output register
// (empty/pop). Insert, finalize and update read the set's row from the
// current bank and then from the old bank (the row memory has one read port)
// and write back in the execute state; an entry moved out of the old bank
// costs one more write. A tick is answered from the idle state without a
// memory access. A bank swap adds a clearing pass over the new current bank,
// and after reset a clearing pass over both banks runs before the first item
// starts. An item starts only once the previous result has been popped.
module syn_proxy_connection_table_top
  import spct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_kind,
  input  wire logic [31:0] in_src_ip,
  input  wire logic [31:0] in_dst_ip,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic [31:0] in_seq_number,
  input  wire logic        in_saw_reset,
  input  wire logic        in_saw_left_fin,
  input  wire logic        in_saw_right_fin,
  input  wire logic        in_is_ack,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_status,
  output logic [31:0]      out_offset,
  output logic [5:0]       out_entry_state,
  output logic             out_swapped
);

  iq_t     iq;
  logic    iq_pop;
  result_t res;
  logic    res_vld;

  spct_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_kind          (in_kind),
    .in_src_ip        (in_src_ip),
    .in_dst_ip        (in_dst_ip),
    .in_src_port      (in_src_port),
    .in_dst_port      (in_dst_port),
    .in_seq_number    (in_seq_number),
    .in_saw_reset     (in_saw_reset),
    .in_saw_left_fin  (in_saw_left_fin),
    .in_saw_right_fin (in_saw_right_fin),
    .in_is_ack        (in_is_ack),
    .iq               (iq),
    .iq_pop           (iq_pop)
  );

  spct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .iq        (iq),
    .iq_pop    (iq_pop),
    .res       (res),
    .res_vld   (res_vld),
    .res_pop   (pop && !empty)
  );

  // result ports
  assign empty           = !res_vld;
  assign out_status      = res.status;
  assign out_offset      = res.offset;
  assign out_entry_state = res.state;
  assign out_swapped     = res.swapped;

  // not-found, await, reset, closed and full results carry zero offset and state
  a_no_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status == ST_NOTFOUND || out_status == ST_AWAIT ||
                out_status == ST_RESET || out_status == ST_CLOSED ||
                out_status == ST_FULL))
    |-> (out_offset == 32'd0 && out_entry_state == 6'd0))
    else $error("entry data on a result without entry");

  // reset and closed results never swap banks
  a_no_swap: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_swapped) |-> (out_status != ST_RESET && out_status != ST_CLOSED))
    else $error("swap on reset or closed result");

  // a done result with an entry is fully verified
  a_done_verified: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_DONE && out_entry_state != 6'd0)
    |-> (out_entry_state[3:2] == 2'b11))
    else $error("done result with unverified entry");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
  import spct_pkg::*;

  typedef struct {
    op_t         kind;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [31:0] seq;
    bit          rst;
    bit          lfin;
    bit          rfin;
    bit          ack;
  } pkt_t;

  typedef struct {
    status_t     status;
    logic [31:0] offset;
    logic [5:0]  state;
    bit          swapped;
  } flow_res_t;

  localparam int NSLOT = 2 * SETS * WAYS;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  logic        push = 0;
  logic        pop = 0;
  logic [1:0]  in_kind = '0;
  logic [31:0] in_src_ip = '0, in_dst_ip = '0, in_seq_number = '0;
  logic [15:0] in_src_port = '0, in_dst_port = '0;
  logic        in_saw_reset = 0, in_saw_left_fin = 0, in_saw_right_fin = 0, in_is_ack = 0;
  logic        full, empty, out_swapped;
  logic [2:0]  out_status;
  logic [31:0] out_offset;
  logic [5:0]  out_entry_state;

  syn_proxy_connection_table_top uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .in_kind(in_kind), .in_src_ip(in_src_ip),
    .in_dst_ip(in_dst_ip), .in_src_port(in_src_port), .in_dst_port(in_dst_port),
    .in_seq_number(in_seq_number), .in_saw_reset(in_saw_reset),
    .in_saw_left_fin(in_saw_left_fin), .in_saw_right_fin(in_saw_right_fin),
    .in_is_ack(in_is_ack), .empty(empty), .pop(pop), .out_status(out_status),
    .out_offset(out_offset), .out_entry_state(out_entry_state),
    .out_swapped(out_swapped)
  );

  // shadow flow table
  logic [63:0] tbl_ka [NSLOT];
  logic [31:0] tbl_kp [NSLOT];
  logic [31:0] tbl_off [NSLOT];
  logic [5:0]  tbl_flg [NSLOT];
  bit          tbl_vld [NSLOT];
  bit          cur_bank;
  logic [31:0] tick_count;
  logic [31:0] age_limit;

  pkt_t      pending_pkts[$];
  flow_res_t expected_res[$];
  pkt_t      flow_pool[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        want_stall = 0;

  // flow key hash to set index
  function automatic int unsigned flow_set(pkt_t p);
    logic [95:0] msg;
    logic [31:0] c;
    msg = {p.sp, p.dp, p.dip, p.sip};
    c = '0;
    for (int i = 0; i < 96; i++) begin
      c = c ^ {31'd0, msg[i]};
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c % SETS;
  endfunction

  function automatic int bank_base(bit bank, int unsigned set);
    return (int'(bank) * SETS + set) * WAYS;
  endfunction

  function automatic int find_flow(int base, logic [63:0] ka, logic [31:0] kp);
    for (int w = 0; w < WAYS; w++)
      if (tbl_vld[base + w] && tbl_ka[base + w] == ka && tbl_kp[base + w] == kp)
        return base + w;
    return -1;
  endfunction

  function automatic int free_slot(int base);
    for (int w = 0; w < WAYS; w++)
      if (!tbl_vld[base + w]) return base + w;
    return -1;
  endfunction

  // find a flow, pulling it from the old bank into the current one if room
  function automatic int locate_flow(int unsigned set, logic [63:0] ka, logic [31:0] kp);
    int cb, s, d;
    cb = bank_base(cur_bank, set);
    s = find_flow(cb, ka, kp);
    if (s >= 0) return s;
    s = find_flow(bank_base(!cur_bank, set), ka, kp);
    if (s < 0) return -1;
    d = free_slot(cb);
    if (d < 0) return s;
    tbl_ka[d] = tbl_ka[s];
    tbl_kp[d] = tbl_kp[s];
    tbl_off[d] = tbl_off[s];
    tbl_flg[d] = tbl_flg[s];
    tbl_vld[d] = 1;
    tbl_vld[s] = 0;
    return d;
  endfunction

  function automatic bit age_table();
    int base;
    if (tick_count <= age_limit) return 0;
    cur_bank = !cur_bank;
    base = bank_base(cur_bank, 0);
    for (int i = 0; i < SETS * WAYS; i++) tbl_vld[base + i] = 0;
    tick_count = '0;
    return 1;
  endfunction

  function automatic flow_res_t predict_flow(pkt_t p);
    flow_res_t   r;
    logic [63:0] ka;
    logic [31:0] kp;
    int unsigned set;
    int          s;
    logic [5:0]  f;
    r = '{ST_DONE, 32'd0, 6'd0, 1'b0};
    ka = {p.sip, p.dip};
    kp = {p.sp, p.dp};
    set = flow_set(p);
    case (p.kind)
      OP_TICK: begin
        if (tick_count != 32'hFFFF_FFFF) tick_count++;
      end
      OP_INSERT: begin
        s = find_flow(bank_base(cur_bank, set), ka, kp);
        if (s < 0) s = free_slot(bank_base(cur_bank, set));
        if (s < 0) r.status = ST_FULL;
        else begin
          tbl_ka[s] = ka;
          tbl_kp[s] = kp;
          tbl_off[s] = p.seq;
          tbl_flg[s] = FLG_LVER;
          tbl_vld[s] = 1;
        end
        r.swapped = age_table();
      end
      OP_FINAL: begin
        s = locate_flow(set, ka, kp);
        if (s < 0) r.status = ST_NOTFOUND;
        else begin
          if ((tbl_flg[s] & FLG_VER) != FLG_LVER) r.status = ST_FLAGS;
          else begin
            tbl_off[s] = p.seq - tbl_off[s] + 32'd1;
            tbl_flg[s] = tbl_flg[s] | FLG_RVER;
          end
          r.offset = tbl_off[s];
          r.state = tbl_flg[s];
        end
        r.swapped = age_table();
      end
      default: begin
        s = locate_flow(set, ka, kp);
        if (s < 0) begin
          r.status = ST_NOTFOUND;
          r.swapped = age_table();
        end else if ((tbl_flg[s] & FLG_VER) == FLG_LVER) begin
          r.status = ST_AWAIT;
          r.swapped = age_table();
        end else if ((tbl_flg[s] & FLG_VER) != FLG_VER) begin
          r.status = ST_FLAGS;
          r.swapped = age_table();
        end else if ((tbl_flg[s] & FLG_RESET) != 6'd0) begin
          r.status = ST_RESET;
        end else begin
          f = tbl_flg[s];
          if (p.rst) f |= FLG_RESET;
          if ((f & FLG_CLOSED) != 6'd0) begin
            tbl_flg[s] = f;
            r.status = ST_CLOSED;
          end else begin
            if ((f & FLG_FINS) == FLG_FINS && p.ack) f |= FLG_CLOSED;
            if (p.lfin) f |= FLG_LFIN;
            if (p.rfin) f |= FLG_RFIN;
            tbl_flg[s] = f;
            r.offset = tbl_off[s];
            r.state = f;
            r.swapped = age_table();
          end
        end
      end
    endcase
    return r;
  endfunction

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n && pending_pkts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      push <= 1'b1;
      in_kind <= pending_pkts[0].kind;
      in_src_ip <= pending_pkts[0].sip;
      in_dst_ip <= pending_pkts[0].dip;
      in_src_port <= pending_pkts[0].sp;
      in_dst_port <= pending_pkts[0].dp;
      in_seq_number <= pending_pkts[0].seq;
      in_saw_reset <= pending_pkts[0].rst;
      in_saw_left_fin <= pending_pkts[0].lfin;
      in_saw_right_fin <= pending_pkts[0].rfin;
      in_is_ack <= pending_pkts[0].ack;
    end else begin
      push <= 1'b0;
    end
  end

  // input transfer: predict the result
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      expected_res.push_back(predict_flow(pending_pkts[0]));
      void'(pending_pkts.pop_front());
    end
  end

  // result pop, with one long hold-off on request
  int  stall_left = 0;
  bit  stall_done = 0;
  always @(negedge clk) begin
    if (want_stall && !stall_done) begin
      stall_left = 400;
      stall_done = 1;
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result transfer: compare with oldest expectation
  always @(posedge clk) begin
    flow_res_t e;
    if (rst_n && pop && !empty) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result status=%0d offset=%h state=%h swapped=%0d",
                 $time, out_status, out_offset, out_entry_state, out_swapped);
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (out_status !== e.status || out_offset !== e.offset ||
            out_entry_state !== e.state || out_swapped !== e.swapped) begin
          $display("%0t: mismatch expected status=%0d offset=%h state=%h swapped=%0d",
                   $time, e.status, e.offset, e.state, e.swapped);
          $display("%0t:          actual   status=%0d offset=%h state=%h swapped=%0d",
                   $time, out_status, out_offset, out_entry_state, out_swapped);
          errors++;
        end
      end
    end
  end

  function automatic pkt_t random_flow();
    pkt_t p;
    p = '{OP_INSERT, $urandom, $urandom, 16'($urandom_range(65535)),
          16'($urandom_range(65535)), $urandom, 1'b0, 1'b0, 1'b0, 1'b0};
    return p;
  endfunction

  function automatic pkt_t flow_in_set(int unsigned set);
    pkt_t p;
    do p = random_flow(); while (flow_set(p) != set);
    return p;
  endfunction

  function automatic pkt_t with_op(pkt_t k, op_t op, logic [31:0] seq, logic [3:0] fl);
    pkt_t p;
    p = k;
    p.kind = op;
    p.seq = seq;
    {p.rst, p.lfin, p.rfin, p.ack} = fl;
    return p;
  endfunction

  task automatic drain_and_settle();
    wait (pending_pkts.size() == 0 && expected_res.size() == 0);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_interval(logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    age_limit = v;
  endtask

  task automatic random_phase(int count);
    pkt_t p;
    int   r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      p = (r < 8) ? random_flow() : flow_pool[$urandom_range(flow_pool.size() - 1)];
      p.seq = $urandom;
      {p.rst, p.lfin, p.rfin, p.ack} = 4'($urandom_range(15));
      if (p.rst && $urandom_range(2) != 0) p.rst = 0;
      r = $urandom_range(99);
      p.kind = (r < 25) ? OP_INSERT : (r < 50) ? OP_FINAL : (r < 85) ? OP_UPDATE : OP_TICK;
      pending_pkts.push_back(p);
    end
  endtask

  // timeout
  initial begin
    #(8 * 4000000);
    $display("FAIL syn_proxy_connection_table_top");
    $finish;
  end

  initial begin
    pkt_t a, b, k;
    int unsigned s0, s1;
    for (int i = 0; i < NSLOT; i++) tbl_vld[i] = 0;
    cur_bank = 0;
    tick_count = '0;
    age_limit = INTERVAL_RST;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: lifecycles of two flows, extremes of the key fields
    a = '{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, '0,
          1'b0, 1'b0, 1'b0, 1'b0};
    b = '{OP_INSERT, 32'h0, 32'h0, 16'h0, 16'h0, '0, 1'b0, 1'b0, 1'b0, 1'b0};
    pending_pkts.push_back(with_op(a, OP_UPDATE, 32'h0, 4'b1111));
    pending_pkts.push_back(with_op(a, OP_INSERT, 32'hFFFF_FFFF, 4'b0000));
    pending_pkts.push_back(with_op(a, OP_UPDATE, 32'h0, 4'b0000));
    pending_pkts.push_back(with_op(a, OP_FINAL, 32'h0, 4'b0000));
    pending_pkts.push_back(with_op(a, OP_FINAL, 32'h5, 4'b0000));
    pending_pkts.push_back(with_op(a, OP_UPDATE, 32'h0, 4'b0001));
    pending_pkts.push_back(with_op(a, OP_UPDATE, 32'h0, 4'b0110));
    pending_pkts.push_back(with_op(a, OP_UPDATE, 32'h0, 4'b0001));
    pending_pkts.push_back(with_op(a, OP_UPDATE, 32'h0, 4'b1000));
    pending_pkts.push_back(with_op(a, OP_UPDATE, 32'h0, 4'b0000));
    pending_pkts.push_back(with_op(b, OP_INSERT, 32'h0, 4'b0000));
    pending_pkts.push_back(with_op(b, OP_FINAL, 32'hFFFF_FFFF, 4'b0000));
    pending_pkts.push_back(with_op(b, OP_UPDATE, 32'h0, 4'b1000));
    pending_pkts.push_back(with_op(b, OP_UPDATE, 32'h0, 4'b0000));
    // five flows into one set: the last finds it full
    s0 = $urandom_range(SETS - 1);
    for (int i = 0; i < 6; i++) begin
      k = flow_in_set(s0);
      flow_pool.push_back(k);
      if (i < 5) pending_pkts.push_back(with_op(k, OP_INSERT, $urandom, 4'b0000));
    end
    pending_pkts.push_back(with_op(b, OP_TICK, 32'h0, 4'b0000));
    pending_pkts.push_back(with_op(a, OP_TICK, 32'h0, 4'b0000));
    drain_and_settle();

    // zero interval: next operation after a tick swaps, then flows move over
    write_interval(32'd0);
    pending_pkts.push_back(with_op(b, OP_TICK, 32'h0, 4'b0000));
    pending_pkts.push_back(with_op(flow_pool[0], OP_FINAL, $urandom, 4'b0000));
    pending_pkts.push_back(with_op(b, OP_UPDATE, 32'h0, 4'b0100));
    pending_pkts.push_back(with_op(a, OP_UPDATE, 32'h0, 4'b0000));

    // pool of flows, crowded sets for full and blocked moves
    s1 = $urandom_range(SETS - 1);
    for (int i = 0; i < 5; i++) flow_pool.push_back(flow_in_set(s1));
    for (int i = 0; i < 8; i++) flow_pool.push_back(random_flow());
    flow_pool.push_back(a);
    flow_pool.push_back(b);
    drain_and_settle();

    write_interval(32'd40);
    send_idle_pct = 21;
    recv_idle_pct = 54;
    random_phase(300);
    want_stall = 1;
    random_phase(350);
    drain_and_settle();

    write_interval(32'd0);
    send_idle_pct = 54;
    recv_idle_pct = 21;
    random_phase(650);
    drain_and_settle();

    write_interval(32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(300);
    drain_and_settle();

    write_interval(32'd15);
    random_phase(330);
    drain_and_settle();

    if (errors == 0) begin
      $display("PASS syn_proxy_connection_table_top");
    end else begin
      $display("FAIL syn_proxy_connection_table_top");
    end
    $finish;
  end

endmodule
